@@ rtl/tsc_pkg.sv @@
`timescale 1ns / 1ps

package tsc_pkg;

	localparam int ANGLE_W       = 32;
	localparam int VALUE_W       = 32;
	localparam int TERMS_W       = 6;
	localparam int TERMS_MAX     = 2**TERMS_W - 1;
	localparam int ACC_W         = 3;
	localparam int MAX_TERMS_DEF = 32;

	// fraction bits of the internal Q10.22 format
	localparam int FRAC = 22;

	// datapath widths, bounded by |angle| <= 360 after reduction
	localparam int MAG_W   = 32;
	localparam int RED_W   = 25;
	localparam int RMAG_W  = 25;
	localparam int R2_W    = 28;
	localparam int DMAG_W  = 30;
	localparam int MUL_A_W = DMAG_W;
	localparam int MUL_B_W = R2_W;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int NUM_W   = PROD_W - FRAC;
	localparam int SUM_W   = 40;
	localparam int EPS_W   = 23;

	// Q10.22 sum to Q2.30 result
	localparam int VAL_SHIFT = 8;
	localparam int KEEP_W    = VALUE_W - VAL_SHIFT;

	// quotient bits retired per divider cycle
	localparam int DIV_BITS = 4;

	// range reduction: quotient by 360 degrees stays below 128
	localparam logic [MAG_W-1:0] DEG360_Q16 = 32'd23592960;
	localparam int RED_STEPS = 7;
	localparam int RK_W      = 3;

	localparam logic [MUL_B_W-1:0] RAD_PER_DEG_Q32 = 28'd74961321;
	localparam int RAD_SHIFT = 26;
	localparam logic [DMAG_W-1:0] ONE_Q22 = 30'd4194304;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef struct packed {
		logic idle;
		logic done;
	} seq_stat_t;

	// stop threshold 10^-acc in Q10.22, seven acts as six
	function automatic logic [EPS_W-1:0] eps_q22(input logic [ACC_W-1:0] acc);
		logic [EPS_W-1:0] e;
		case (acc)
			3'd0: e = 23'd4194304;
			3'd1: e = 23'd419430;
			3'd2: e = 23'd41943;
			3'd3: e = 23'd4194;
			3'd4: e = 23'd419;
			3'd5: e = 23'd42;
			default: e = 23'd4;
		endcase
		return e;
	endfunction

endpackage

@@ rtl/tsc_mul.sv @@
`timescale 1ns / 1ps

module tsc_mul (
	input  logic                         clk,
	input  logic [tsc_pkg::MUL_A_W-1:0]  a,
	input  logic [tsc_pkg::MUL_B_W-1:0]  b,
	output logic [tsc_pkg::PROD_W-1:0]   prod
);
	import tsc_pkg::*;

	logic [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

@@ rtl/tsc_div.sv @@
`timescale 1ns / 1ps

module tsc_div #(
	parameter int DEN_W = 13
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tsc_pkg::NUM_W-1:0]   num,
	input  logic [DEN_W-1:0]            den,
	output tsc_pkg::div_stat_t          stat,
	output logic [tsc_pkg::NUM_W-1:0]   quot
);
	import tsc_pkg::*;

	localparam int STEPS = (NUM_W + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_W = STEPS * DIV_BITS;
	localparam int CW    = $clog2(STEPS + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [PAD_W-1:0] num_q;
	logic [PAD_W-1:0] quot_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;

	logic [DEN_W:0]    r;
	logic [DIV_BITS-1:0] qb;
	logic [DEN_W-1:0]  rem_nxt;

	// restoring division, DIV_BITS quotient bits per cycle
	always_comb begin
		r  = {1'b0, rem_q};
		qb = '0;
		for (int i = 0; i < DIV_BITS; i++) begin
			r = {r[DEN_W-1:0], num_q[PAD_W-1-i]};
			if (r >= {1'b0, den_q}) begin
				r = r - {1'b0, den_q};
				qb[DIV_BITS-1-i] = 1'b1;
			end
		end
		rem_nxt = r[DEN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q  <= PAD_W'(num);
			quot_q <= '0;
			rem_q  <= '0;
			den_q  <= den;
		end else if (busy_q) begin
			num_q  <= num_q << DIV_BITS;
			quot_q <= PAD_W'({quot_q, qb});
			rem_q  <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q[NUM_W-1:0];

endmodule

@@ rtl/tsc_seq.sv @@
`timescale 1ns / 1ps

module tsc_seq #(
	parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [tsc_pkg::ANGLE_W-1:0]   angle,
	input  logic                          cos_sel,
	input  logic [tsc_pkg::ACC_W-1:0]     acc,
	input  logic                          take,
	output tsc_pkg::seq_stat_t            stat,
	output logic [tsc_pkg::VALUE_W-1:0]   value,
	output logic [tsc_pkg::TERMS_W-1:0]   terms,
	output logic                          sat
);
	import tsc_pkg::*;

	localparam int CNT_W = $clog2(MAX_TERMS + 1);
	localparam int DEN_W = $clog2(4 * MAX_TERMS * MAX_TERMS + 2 * MAX_TERMS + 1);
	localparam int TX_W  = (CNT_W > TERMS_W) ? CNT_W : TERMS_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_REDUCE,
		S_RAD,
		S_RAD_RES,
		S_SQ,
		S_SQ_RES,
		S_TERM,
		S_TERM_DIV,
		S_DIV_WAIT,
		S_FIN
	} state_t;

	state_t                  state_q;
	logic                    cos_q;
	logic [EPS_W-1:0]        eps_q;
	logic                    neg_q;
	logic [MAG_W-1:0]        rem_q;
	logic [RK_W-1:0]         k_q;
	logic [RMAG_W-1:0]       rmag_q;
	logic [R2_W-1:0]         r2_q;
	logic [DMAG_W-1:0]       dmag_q;
	logic                    dneg_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        terms_q;
	logic [DEN_W-1:0]        den_q;

	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic [PROD_W-1:0]       prod;
	logic                    div_start;
	div_stat_t               div_stat;
	logic [NUM_W-1:0]        quot;

	logic [MAG_W-1:0]        mag_in;
	logic [MAG_W-1:0]        dk;
	logic [PROD_W-1:0]       rnd_rad;
	logic [PROD_W-1:0]       rnd_sq;
	logic [DMAG_W-1:0]       dmag_new;
	logic signed [SUM_W-1:0] dext;
	logic signed [SUM_W-1:0] rext;
	logic signed [SUM_W-1:0] sum_nxt;
	logic [CNT_W-1:0]        terms_nxt;
	logic                    more;
	logic [SUM_W-KEEP_W:0]   top_bits;
	logic [TX_W-1:0]         tx;

	tsc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	tsc_div #(
		.DEN_W (DEN_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[PROD_W-1:FRAC]),
		.den    (den_q),
		.stat   (div_stat),
		.quot   (quot)
	);

	// operand select for the shared multiplier
	always_comb begin
		case (state_q)
			S_RAD: begin
				mul_a = MUL_A_W'(rem_q[RED_W-1:0]);
				mul_b = RAD_PER_DEG_Q32;
			end
			S_SQ: begin
				mul_a = MUL_A_W'(rmag_q);
				mul_b = MUL_B_W'(rmag_q);
			end
			default: begin
				mul_a = dmag_q;
				mul_b = r2_q;
			end
		endcase
	end

	assign div_start = (state_q == S_TERM_DIV);

	assign mag_in    = angle[ANGLE_W-1] ? (~angle + MAG_W'(1)) : angle;
	assign dk        = DEG360_Q16 << k_q;
	assign rnd_rad   = prod + (PROD_W'(1) << (RAD_SHIFT - 1));
	assign rnd_sq    = prod + (PROD_W'(1) << (FRAC - 1));
	assign dmag_new  = DMAG_W'(quot);
	assign dext      = signed'(SUM_W'(dmag_new));
	assign rext      = signed'(SUM_W'(rmag_q));
	// the new term carries the opposite sign of the previous one
	assign sum_nxt   = dneg_q ? (sum_q + dext) : (sum_q - dext);
	assign terms_nxt = terms_q + CNT_W'(1);
	assign more      = (dmag_new >= DMAG_W'(eps_q)) && (terms_nxt < CNT_W'(MAX_TERMS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						cos_q <= cos_sel;
						eps_q <= eps_q22(acc);
						neg_q <= angle[ANGLE_W-1];
						rem_q <= mag_in;
						k_q   <= RK_W'(RED_STEPS - 1);
						// exactly 360 is left as it is
						state_q <= (mag_in > DEG360_Q16) ? S_REDUCE : S_RAD;
					end
				end
				S_REDUCE: begin
					if (rem_q >= dk)
						rem_q <= rem_q - dk;
					k_q <= k_q - RK_W'(1);
					if (k_q == '0)
						state_q <= S_RAD;
				end
				S_RAD: begin
					state_q <= S_RAD_RES;
				end
				S_RAD_RES: begin
					rmag_q  <= RMAG_W'(rnd_rad >> RAD_SHIFT);
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_SQ_RES;
				end
				S_SQ_RES: begin
					r2_q    <= R2_W'(rnd_sq >> FRAC);
					terms_q <= CNT_W'(1);
					if (cos_q) begin
						dmag_q <= ONE_Q22;
						dneg_q <= 1'b0;
						sum_q  <= signed'(SUM_W'(ONE_Q22));
						den_q  <= DEN_W'(2);
					end else begin
						dmag_q <= DMAG_W'(rmag_q);
						dneg_q <= neg_q && (rmag_q != '0);
						sum_q  <= neg_q ? -rext : rext;
						den_q  <= DEN_W'(6);
					end
					state_q <= S_TERM;
				end
				S_TERM: begin
					state_q <= S_TERM_DIV;
				end
				S_TERM_DIV: begin
					state_q <= S_DIV_WAIT;
				end
				S_DIV_WAIT: begin
					if (div_stat.done) begin
						dmag_q  <= dmag_new;
						dneg_q  <= !dneg_q;
						sum_q   <= sum_nxt;
						terms_q <= terms_nxt;
						// next factorial pair: 8t+6 for sine, 8t+2 for cosine
						den_q   <= den_q + (DEN_W'(terms_q) << 3)
							+ (cos_q ? DEN_W'(2) : DEN_W'(6));
						state_q <= more ? S_TERM : S_FIN;
					end
				end
				S_FIN: begin
					if (take)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// clip to Q2.30 when the bits above the kept range disagree
	assign top_bits = sum_q[SUM_W-1:KEEP_W-1];
	assign sat      = !(&top_bits) && (|top_bits);
	assign value    = !sat ? {sum_q[KEEP_W-1:0], {VAL_SHIFT{1'b0}}}
		: (sum_q[SUM_W-1] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}});

	assign tx    = TX_W'(terms_q);
	assign terms = (tx > TX_W'(TERMS_MAX)) ? TERMS_W'(TERMS_MAX) : tx[TERMS_W-1:0];

	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_FIN);

endmodule

@@ rtl/taylor_sine_cosine.sv @@
`timescale 1ns / 1ps
// one angle at a time: a new angle is accepted only once the previous result has gone to the output register
// range reduction runs only when |angle| > 360 degrees
// each series term takes one pass of the shared 30x28 multiplier and one run of the radix-16 divider
// a finished result waits in the output register while the next angle is worked on
// arst_n clears all control state, function_select to 0 and accuracy_digits to 6

module taylor_sine_cosine #(
	parameter int MAX_TERMS = tsc_pkg::MAX_TERMS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] angle_deg

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] series_value, [37:32] terms_used, [39:38] zero
	output logic        m_tuser,   // [0] saturated

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import tsc_pkg::*;

	localparam logic REG_FUNC_SEL = 1'b0;
	localparam logic REG_ACC      = 1'b1;
	localparam logic [ACC_W-1:0] ACC_RESET = 3'd6;

	logic               func_sel_q;
	logic [ACC_W-1:0]   acc_q;
	logic               cfg_wr;

	seq_stat_t          stat;
	logic               start;
	logic               res_take;
	logic [VALUE_W-1:0] res_value;
	logic [TERMS_W-1:0] res_terms;
	logic               res_sat;

	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [TERMS_W-1:0] out_terms_q;
	logic               out_sat_q;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			func_sel_q <= 1'b0;
			acc_q      <= ACC_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_FUNC_SEL: func_sel_q <= pwdata[0];
				REG_ACC:      acc_q      <= pwdata[ACC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FUNC_SEL: prdata = {31'b0, func_sel_q};
			REG_ACC:      prdata = {{(32-ACC_W){1'b0}}, acc_q};
			default:      prdata = '0;
		endcase
	end

	assign s_tready = stat.idle;
	assign start    = s_tvalid && s_tready;
	assign res_take = stat.done && (!out_valid_q || m_tready);

	tsc_seq #(
		.MAX_TERMS (MAX_TERMS)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.angle   (s_tdata),
		.cos_sel (func_sel_q),
		.acc     (acc_q),
		.take    (res_take),
		.stat    (stat),
		.value   (res_value),
		.terms   (res_terms),
		.sat     (res_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_value_q <= res_value;
			out_terms_q <= res_terms;
			out_sat_q   <= res_sat;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_terms_q, out_value_q};
	assign m_tuser  = out_sat_q;

	// the sequencer leaves idle right after taking an angle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input taken while sequencer busy");

	// at least one term is always reported
	a_terms_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[37:32] != 6'd0))
		else $error("result beat with zero terms");

	// a clipped result sits on one of the rails
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |->
		(m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000))
		else $error("saturated flag without rail value");

endmodule
